// ===== rtl/core/eg_pkg.sv =====
`default_nettype none
package eg_pkg;

    localparam int DEF_WIDTH = 64;
    localparam int FIELD_W   = 64;

    localparam int S_TDATA_W = 4 * FIELD_W;
    localparam int M_TDATA_W = ((2 * FIELD_W + 2 + 7) / 8) * 8;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_MODULUS    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GENERATOR  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PUBLIC     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PRIVATE    = 2'd3;

    localparam logic OP_SIGN   = 1'b0;
    localparam logic OP_VERIFY = 1'b1;

    localparam int RST_MODULUS   = 23;
    localparam int RST_GENERATOR = 5;
    localparam int RST_PUBLIC    = 8;
    localparam int RST_PRIVATE   = 6;

endpackage
`default_nettype wire

// ===== rtl/core/eg_mul.sv =====
`default_nettype none
module eg_mul import eg_pkg::*; #(
    parameter int W = DEF_WIDTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic         i_div,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic [W-1:0] i_m,
    output logic              o_done,
    output logic [W-1:0]      o_rem,
    output logic [W-1:0]      o_quot
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic          r_div;
    logic [W-1:0]  r_r;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_m;
    logic [W-1:0]  r_q;

    logic          bit_b;
    logic [W:0]    m_ext;
    logic [W:0]    t;
    logic          ge1;
    logic [W:0]    t1;
    logic [W-1:0]  addend;
    logic [W:0]    u;
    logic [W:0]    n_r;

    // Each beat of the loop takes the top bit of the B operand: the partial
    // value is doubled modulo M, then either the bit is shifted in (division)
    // or A is added modulo M (multiplication).
    always_comb begin
        bit_b  = r_b[W-1];
        m_ext  = {1'b0, r_m};
        t      = {r_r, 1'b0} + {{W{1'b0}}, (r_div & bit_b)};
        ge1    = (t >= m_ext);
        t1     = ge1 ? (t - m_ext) : t;
        addend = (bit_b && !r_div) ? r_a : '0;
        u      = {1'b0, t1[W-1:0]} + {1'b0, addend};
        n_r    = (u >= m_ext) ? (u - m_ext) : u;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_div  <= i_div;
                r_r    <= '0;
                r_q    <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_m    <= i_m;
            end else if (r_busy) begin
                r_r   <= n_r[W-1:0];
                r_b   <= {r_b[W-2:0], 1'b0};
                r_q   <= {r_q[W-2:0], ge1};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_r;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// ===== rtl/core/eg_pow.sv =====
`default_nettype none
module eg_pow import eg_pkg::*; #(
    parameter int W = DEF_WIDTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_base,
    input  wire logic [W-1:0] i_exp,
    input  wire logic [W-1:0] i_m,
    output logic              o_done,
    output logic [W-1:0]      o_result
);

    localparam int CW = $clog2(W + 1);

    typedef enum logic [1:0] {
        P_IDLE,
        P_RED,
        P_MUL,
        P_SQR
    } t_pstate;

    t_pstate       r_state;
    logic          r_wait;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_base;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_exp;
    logic [W-1:0]  r_m;

    logic          mul_start;
    logic [W-1:0]  mul_a;
    logic [W-1:0]  mul_b;
    logic          mul_done;
    logic [W-1:0]  mul_rem;
    logic [W-1:0]  mul_quot;

    always_comb begin
        mul_start = (r_state != P_IDLE) && !r_wait;
        case (r_state)
            P_RED: begin
                mul_a = W'(1);
                mul_b = r_base;
            end
            P_MUL: begin
                mul_a = r_acc;
                mul_b = r_base;
            end
            default: begin
                mul_a = r_base;
                mul_b = r_base;
            end
        endcase
    end

    eg_mul #(.W(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_div   (1'b0),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_m     (r_m),
        .o_done  (mul_done),
        .o_rem   (mul_rem),
        .o_quot  (mul_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_wait  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                P_IDLE: begin
                    if (i_start) begin
                        r_base  <= i_base;
                        r_exp   <= i_exp;
                        r_m     <= i_m;
                        r_acc   <= W'(1);
                        r_cnt   <= CW'(W);
                        r_wait  <= 1'b0;
                        r_state <= P_RED;
                    end
                end
                P_RED: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_base  <= mul_rem;
                        r_state <= r_exp[0] ? P_MUL : P_SQR;
                    end
                end
                P_MUL: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_acc   <= mul_rem;
                        r_state <= P_SQR;
                    end
                end
                P_SQR: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_wait <= 1'b0;
                        r_base <= mul_rem;
                        r_exp  <= {1'b0, r_exp[W-1:1]};
                        r_cnt  <= r_cnt - CW'(1);
                        if (r_cnt == CW'(1)) begin
                            r_done  <= 1'b1;
                            r_state <= P_IDLE;
                        end else begin
                            r_state <= r_exp[1] ? P_MUL : P_SQR;
                        end
                    end
                end
                default: begin
                    r_state <= P_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule
`default_nettype wire

// ===== rtl/core/elgamal_sign_verify.sv =====
// Work per beat: a sign beat computes g^R, five products and an extended Euclid loop of
// up to about 1.44*WIDTH steps, each a division and a product. A verify beat computes
// three modular powers and one product.
// One beat is worked on at a time; the next can be taken in the cycle after the result is
// registered, and the serial shift-add multiplier sets the pace.
// Reset is synchronous and active low; it loads the default key registers.
`default_nettype none
module elgamal_sign_verify import eg_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // message, nonce, sig_first, sig_second (64 bits each, from bit 0 up)
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // op
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // out_first, out_second, accepted, nonce_error, zero padding
    output logic [M_TDATA_W-1:0]       o_m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [FIELD_W-1:0]    i_cfg_data
);

    localparam int W = WIDTH;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPOW,
        S_IRED,
        S_ICHK,
        S_IDIV,
        S_IMUL,
        S_DRED,
        S_DMUL,
        S_MRED,
        S_SMUL,
        S_VPOW1,
        S_VPOW2,
        S_VPOW3,
        S_VMUL,
        S_OUT
    } t_state;

    t_state       r_state;
    logic         r_wait;
    logic [W-1:0] r_mod;
    logic [W-1:0] r_gen;
    logic [W-1:0] r_pub;
    logic [W-1:0] r_priv;
    logic [W-1:0] r_n;
    logic [W-1:0] r_msg;
    logic [W-1:0] r_nonce;
    logic [W-1:0] r_s1;
    logic [W-1:0] r_s2;
    logic [W-1:0] r_sig1;
    logic [W-1:0] r_r0;
    logic [W-1:0] r_r1;
    logic [W-1:0] r_t0;
    logic [W-1:0] r_t1;
    logic [W-1:0] r_q;
    logic [W-1:0] r_x;
    logic [W-1:0] r_y;
    logic [W-1:0] r_res_first;
    logic [W-1:0] r_res_second;
    logic         r_res_acc;
    logic         r_res_err;
    logic         r_out_valid;
    logic [W-1:0] r_out_first;
    logic [W-1:0] r_out_second;
    logic         r_out_acc;
    logic         r_out_err;

    logic         in_beat;
    logic         out_free;
    logic [W-1:0] in_msg;
    logic [W-1:0] in_nonce;
    logic [W-1:0] in_s1;
    logic [W-1:0] in_s2;
    logic [W-1:0] mod_lo;

    logic         mul_start;
    logic         mul_div;
    logic [W-1:0] mul_a;
    logic [W-1:0] mul_b;
    logic [W-1:0] mul_m;
    logic         mul_done;
    logic [W-1:0] mul_rem;
    logic [W-1:0] mul_quot;

    logic         pow_start;
    logic [W-1:0] pow_base;
    logic [W-1:0] pow_exp;
    logic         pow_done;
    logic [W-1:0] pow_result;

    logic [W-1:0] t_next;
    logic [W-1:0] diff;

    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign in_msg   = i_s_axis_tdata[0*FIELD_W +: W];
    assign in_nonce = i_s_axis_tdata[1*FIELD_W +: W];
    assign in_s1    = i_s_axis_tdata[2*FIELD_W +: W];
    assign in_s2    = i_s_axis_tdata[3*FIELD_W +: W];
    assign mod_lo   = W'(3);

    // Subtraction modulo n of two values already below n.
    assign t_next = (r_t0 >= mul_rem) ? (r_t0 - mul_rem) : (r_t0 - mul_rem + r_n);
    assign diff   = (mul_rem >= r_y) ? (mul_rem - r_y) : (mul_rem - r_y + r_n);

    always_comb begin
        mul_start = 1'b0;
        pow_start = 1'b0;
        mul_div   = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_m     = r_n;
        pow_base  = r_gen;
        pow_exp   = r_nonce;
        case (r_state)
            S_SPOW: begin
                pow_start = !r_wait;
            end
            S_IRED: begin
                mul_start = !r_wait;
                mul_div   = 1'b1;
                mul_b     = r_nonce;
            end
            S_IDIV: begin
                mul_start = !r_wait;
                mul_div   = 1'b1;
                mul_b     = r_r0;
                mul_m     = r_r1;
            end
            S_IMUL: begin
                mul_start = !r_wait;
                mul_a     = r_t1;
                mul_b     = r_q;
            end
            S_DRED: begin
                mul_start = !r_wait;
                mul_div   = 1'b1;
                mul_b     = r_priv;
            end
            S_DMUL: begin
                mul_start = !r_wait;
                mul_a     = r_x;
                mul_b     = r_sig1;
            end
            S_MRED: begin
                mul_start = !r_wait;
                mul_div   = 1'b1;
                mul_b     = r_msg;
            end
            S_SMUL: begin
                mul_start = !r_wait;
                mul_a     = r_x;
                mul_b     = r_t0;
            end
            S_VPOW1: begin
                pow_start = !r_wait;
                pow_exp   = r_msg;
            end
            S_VPOW2: begin
                pow_start = !r_wait;
                pow_base  = r_pub;
                pow_exp   = r_s1;
            end
            S_VPOW3: begin
                pow_start = !r_wait;
                pow_base  = r_s1;
                pow_exp   = r_s2;
            end
            S_VMUL: begin
                mul_start = !r_wait;
                mul_a     = r_y;
                mul_b     = r_q;
                mul_m     = r_mod;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    eg_mul #(.W(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_div   (mul_div),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_m     (mul_m),
        .o_done  (mul_done),
        .o_rem   (mul_rem),
        .o_quot  (mul_quot)
    );

    eg_pow #(.W(W)) u_pow (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (pow_start),
        .i_base   (pow_base),
        .i_exp    (pow_exp),
        .i_m      (r_mod),
        .o_done   (pow_done),
        .o_result (pow_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_mod       <= W'(RST_MODULUS);
            r_gen       <= W'(RST_GENERATOR);
            r_pub       <= W'(RST_PUBLIC);
            r_priv      <= W'(RST_PRIVATE);
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    REG_MODULUS:   r_mod  <= i_cfg_data[W-1:0];
                    REG_GENERATOR: r_gen  <= i_cfg_data[W-1:0];
                    REG_PUBLIC:    r_pub  <= i_cfg_data[W-1:0];
                    REG_PRIVATE:   r_priv <= i_cfg_data[W-1:0];
                    default:       r_mod  <= r_mod;
                endcase
            end

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state != S_IDLE && r_state != S_ICHK && r_state != S_OUT) begin
                if (!r_wait) begin
                    r_wait <= 1'b1;
                end else if (mul_done || pow_done) begin
                    r_wait <= 1'b0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_msg        <= in_msg;
                        r_nonce      <= in_nonce;
                        r_s1         <= in_s1;
                        r_s2         <= in_s2;
                        r_n          <= r_mod - W'(1);
                        r_res_first  <= '0;
                        r_res_second <= '0;
                        r_res_acc    <= 1'b0;
                        r_res_err    <= (i_s_axis_tuser == OP_SIGN) && (r_mod < mod_lo);
                        r_wait       <= 1'b0;
                        if (i_s_axis_tuser == OP_SIGN) begin
                            if (r_mod < mod_lo) begin
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_SPOW;
                            end
                        end else begin
                            if (r_mod < mod_lo || in_s1 == '0 || in_s1 >= r_mod) begin
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_VPOW1;
                            end
                        end
                    end
                end
                S_SPOW: begin
                    if (r_wait && pow_done) begin
                        r_sig1      <= pow_result;
                        r_res_first <= pow_result;
                        r_state     <= S_IRED;
                    end
                end
                S_IRED: begin
                    if (r_wait && mul_done) begin
                        r_r0    <= r_n;
                        r_r1    <= mul_rem;
                        r_t0    <= '0;
                        r_t1    <= W'(1);
                        r_state <= S_ICHK;
                    end
                end
                S_ICHK: begin
                    if (r_r1 != '0) begin
                        r_state <= S_IDIV;
                    end else if (r_r0 == W'(1)) begin
                        r_state <= S_DRED;
                    end else begin
                        r_res_err <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                S_IDIV: begin
                    if (r_wait && mul_done) begin
                        r_q     <= mul_quot;
                        r_x     <= mul_rem;
                        r_state <= S_IMUL;
                    end
                end
                S_IMUL: begin
                    if (r_wait && mul_done) begin
                        r_t0    <= r_t1;
                        r_t1    <= t_next;
                        r_r0    <= r_r1;
                        r_r1    <= r_x;
                        r_state <= S_ICHK;
                    end
                end
                S_DRED: begin
                    if (r_wait && mul_done) begin
                        r_x     <= mul_rem;
                        r_state <= S_DMUL;
                    end
                end
                S_DMUL: begin
                    if (r_wait && mul_done) begin
                        r_y     <= mul_rem;
                        r_state <= S_MRED;
                    end
                end
                S_MRED: begin
                    if (r_wait && mul_done) begin
                        r_x     <= diff;
                        r_state <= S_SMUL;
                    end
                end
                S_SMUL: begin
                    if (r_wait && mul_done) begin
                        r_res_second <= mul_rem;
                        r_state      <= S_OUT;
                    end
                end
                S_VPOW1: begin
                    if (r_wait && pow_done) begin
                        r_x     <= pow_result;
                        r_state <= S_VPOW2;
                    end
                end
                S_VPOW2: begin
                    if (r_wait && pow_done) begin
                        r_y     <= pow_result;
                        r_state <= S_VPOW3;
                    end
                end
                S_VPOW3: begin
                    if (r_wait && pow_done) begin
                        r_q     <= pow_result;
                        r_state <= S_VMUL;
                    end
                end
                S_VMUL: begin
                    if (r_wait && mul_done) begin
                        r_res_acc <= (mul_rem == r_x);
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_first  <= r_res_first;
                        r_out_second <= r_res_second;
                        r_out_acc    <= r_res_acc;
                        r_out_err    <= r_res_err;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - 2 * FIELD_W - 2){1'b0}}, r_out_err, r_out_acc,
                              FIELD_W'(r_out_second), FIELD_W'(r_out_first)};

endmodule
`default_nettype wire

// ===== rtl/core/eg_checker.sv =====
`default_nettype none
module eg_checker import eg_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input wire logic                  i_cfg_valid,
    input wire logic                  o_cfg_ready
);

    // A result beat holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // Only one request is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken again while a request is in work");

    // A result never reports both a valid signature and a bad nonce.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[2*FIELD_W] && o_m_axis_tdata[2*FIELD_W+1]))
        else $error("accepted and nonce_error both set");

    // An accepted verify result carries no signature words.
    a_verify_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2*FIELD_W] |->
            o_m_axis_tdata[2*FIELD_W-1:0] == '0)
        else $error("verify result with nonzero signature words");

    // The configuration channel never stalls.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind elgamal_sign_verify eg_checker u_eg_checker (.*);
`default_nettype wire

// ===== dv/elgamal_sign_verify_tb.sv =====
`timescale 1ns / 1ps
module elgamal_sign_verify_tb;
    import eg_pkg::*;

    localparam int IDLE_SETTLE = 30000;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct packed {
        logic [63:0] first;
        logic [63:0] second;
        logic        accepted;
        logic        nonce_error;
    } t_sig_result;

    typedef struct {
        logic        op;
        logic [63:0] msg;
        logic [63:0] nonce;
        logic [63:0] s1;
        logic [63:0] s2;
        logic        has_exp;
        t_sig_result exp;
    } t_sig_request;

    logic                  clk;
    logic                  rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [S_TDATA_W-1:0]  s_data;
    logic                  s_user;
    logic                  m_valid;
    logic                  m_ready;
    logic [M_TDATA_W-1:0]  m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [FIELD_W-1:0]    cfg_data;

    logic [63:0] key_p, key_g, key_e2, key_d;
    t_sig_result pending_results[$];
    int          error_count;
    int          results_seen;
    int          stall_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          sign_count, verify_count, accept_count, nonce_err_count;

    elgamal_sign_verify i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] submod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        x = x % m;
        y = y % m;
        return (x >= y) ? x - y : x + (m - y);
    endfunction

    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, a % m} * {64'd0, b % m};
        return 64'(prod % {64'd0, m});
    endfunction

    function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
        logic [63:0] r;
        r = 64'd1 % m;
        base = base % m;
        while (e != 0) begin
            if (e[0]) begin
                r = mulmod(r, base, m);
            end
            base = mulmod(base, base, m);
            e = e >> 1;
        end
        return r;
    endfunction

    // Extended Euclid; returns 1 and the inverse when gcd(a, n) is one.
    function automatic logic invmod(logic [63:0] a, logic [63:0] n, output logic [63:0] inv);
        logic [63:0] r0, r1, t0, t1, q, tmp;
        r0 = n;
        r1 = a % n;
        t0 = 64'd0;
        t1 = 64'd1;
        inv = 64'd0;
        while (r1 != 0) begin
            q = r0 / r1;
            tmp = r0 - q * r1;
            r0 = r1;
            r1 = tmp;
            tmp = submod(t0, mulmod(q, t1, n), n);
            t0 = t1;
            t1 = tmp;
        end
        if (r0 != 1) begin
            return 1'b0;
        end
        inv = t0;
        return 1'b1;
    endfunction

    function automatic t_sig_result predict_signature(t_sig_request rq);
        t_sig_result res;
        logic [63:0] n, rinv, diff;
        res = '0;
        if (rq.op == OP_SIGN) begin
            if (key_p < 3) begin
                res.nonce_error = 1'b1;
            end else begin
                n = key_p - 64'd1;
                res.first = powmod(key_g, rq.nonce, key_p);
                if (!invmod(rq.nonce, n, rinv)) begin
                    res.nonce_error = 1'b1;
                end else begin
                    diff = submod(rq.msg, mulmod(key_d, res.first, n), n);
                    res.second = mulmod(diff, rinv, n);
                end
            end
        end else if (key_p >= 3 && rq.s1 != 0 && rq.s1 < key_p) begin
            res.accepted = (powmod(key_g, rq.msg, key_p) ==
                mulmod(powmod(key_e2, rq.s1, key_p), powmod(rq.s1, rq.s2, key_p), key_p));
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d, %s: got %h, expected %h", results_seen, what, got,
            want);
        error_count++;
    endtask

    // Result side: random stalls and the checker.
    always @(posedge clk) begin
        t_sig_result got, want;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_data[63:0], m_data[127:64], m_data[128], m_data[129]};
                if (pending_results.size() == 0) begin
                    $display("result %0d arrived with nothing expected", results_seen);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.first !== want.first) begin
                        report_mismatch("out_first", got.first, want.first);
                    end
                    if (got.second !== want.second) begin
                        report_mismatch("out_second", got.second, want.second);
                    end
                    if (got.accepted !== want.accepted) begin
                        report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
                    end
                    if (got.nonce_error !== want.nonce_error) begin
                        report_mismatch("nonce_error", 64'(got.nonce_error),
                            64'(want.nonce_error));
                    end
                end
                results_seen++;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_key(logic [CFG_ADDR_W-1:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODULUS:   key_p = value;
            REG_GENERATOR: key_g = value;
            REG_PUBLIC:    key_e2 = value;
            default:       key_d = value;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic load_key(logic [63:0] p, logic [63:0] g, logic [63:0] e2, logic [63:0] d);
        wait_drained();
        write_key(REG_MODULUS, p);
        write_key(REG_GENERATOR, g);
        write_key(REG_PUBLIC, e2);
        write_key(REG_PRIVATE, d);
    endtask

    task automatic send_request(t_sig_request rq);
        t_sig_result want;
        while ($urandom_range(99) < send_idle_pct) begin
            @(posedge clk);
        end
        want = predict_signature(rq);
        if (rq.has_exp && want !== rq.exp) begin
            $display("directed row disagrees with prediction for message %h", rq.msg);
            error_count++;
        end
        s_valid <= 1'b1;
        s_user <= rq.op;
        s_data <= {rq.s2, rq.s1, rq.nonce, rq.msg};
        do @(posedge clk); while (!s_ready);
        pending_results.insert(pending_results.size(), want);
        if (rq.op == OP_SIGN) begin
            sign_count++;
            nonce_err_count += int'(want.nonce_error);
        end else begin
            verify_count++;
            accept_count += int'(want.accepted);
        end
        s_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic t_sig_request make_request(logic op, logic [63:0] msg,
        logic [63:0] nonce, logic [63:0] s1, logic [63:0] s2);
        t_sig_request rq;
        rq.op = op;
        rq.msg = msg;
        rq.nonce = nonce;
        rq.s1 = s1;
        rq.s2 = s2;
        rq.has_exp = 1'b0;
        rq.exp = '0;
        return rq;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // A random sign followed by a verify of its own signature, sometimes corrupted.
    task automatic sign_and_verify(logic [63:0] nonce_max);
        t_sig_request rq;
        t_sig_result sig;
        logic [63:0] msg, nonce;
        msg = ($urandom_range(3) == 0) ? rand64() : rand64() % key_p;
        nonce = ($urandom_range(3) == 0) ? rand64() : 64'($urandom()) % nonce_max;
        rq = make_request(OP_SIGN, msg, nonce, rand64(), rand64());
        sig = predict_signature(rq);
        send_request(rq);
        if ($urandom_range(3) == 0) begin
            msg ^= 64'd1 << $urandom_range(63);
        end
        send_request(make_request(OP_VERIFY, msg, rand64(), sig.first, sig.second));
    endtask

    // Directed stimulus; columns: op, message, nonce, S1, S2, expectation known, expected.
    t_sig_request directed[];

    initial begin
        t_sig_request rq;
        logic [63:0] d, pbig;
        rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        s_user = OP_SIGN;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr = REG_MODULUS;
        cfg_data = '0;
        error_count = 0;
        results_seen = 0;
        stall_cycles = 0;
        sign_count = 0;
        verify_count = 0;
        accept_count = 0;
        nonce_err_count = 0;
        send_idle_pct = 34;
        recv_idle_pct = 61;
        key_p = 64'(RST_MODULUS);
        key_g = 64'(RST_GENERATOR);
        key_e2 = 64'(RST_PUBLIC);
        key_d = 64'(RST_PRIVATE);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = new[12];
        directed[0] = make_request(OP_SIGN, 64'd10, 64'd3, 64'd0, 64'd0);
        directed[1] = make_request(OP_SIGN, 64'd10, 64'd2, 64'd0, 64'd0);
        directed[1].has_exp = 1'b1;
        directed[1].exp = '{64'd2, 64'd0, 1'b0, 1'b1};
        directed[2] = make_request(OP_SIGN, '1, '1, '1, '1);
        directed[3] = make_request(OP_SIGN, 64'd0, 64'd0, 64'd0, 64'd0);
        directed[3].has_exp = 1'b1;
        directed[3].exp = '{64'd1, 64'd0, 1'b0, 1'b1};
        directed[4] = make_request(OP_VERIFY, 64'd10, '1, 64'd0, 64'd5);
        directed[4].has_exp = 1'b1;
        directed[4].exp = '0;
        directed[5] = make_request(OP_VERIFY, 64'd10, 64'd0, 64'd23, 64'd5);
        directed[5].has_exp = 1'b1;
        directed[5].exp = '0;
        directed[6] = make_request(OP_VERIFY, 64'd10, 64'd0, '1, '1);
        directed[6].has_exp = 1'b1;
        directed[6].exp = '0;
        directed[7] = make_request(OP_VERIFY, 64'd10, 64'd0, 64'd10, 64'd5);
        directed[8] = make_request(OP_VERIFY, '1, 64'd0, 64'd22, '1);
        directed[9] = make_request(OP_VERIFY, 64'd0, 64'd0, 64'd1, 64'd0);
        directed[10] = make_request(OP_SIGN, 64'h5555_5555_5555_5555, 64'd25, 64'd0, 64'd0);
        directed[11] = make_request(OP_SIGN, 64'haaaa_aaaa_aaaa_aaaa, 64'd45, 64'd0, 64'd0);
        foreach (directed[i]) begin
            send_request(directed[i]);
        end
        sign_and_verify(64'd22);

        // Degenerate moduli: below three, every request collapses to an error or a reject.
        load_key(64'd2, 64'd1, 64'd0, 64'd0);
        rq = make_request(OP_SIGN, 64'd7, 64'd1, 64'd0, 64'd0);
        rq.has_exp = 1'b1;
        rq.exp = '{64'd0, 64'd0, 1'b0, 1'b1};
        send_request(rq);
        rq = make_request(OP_VERIFY, 64'd7, 64'd0, 64'd1, 64'd1);
        rq.has_exp = 1'b1;
        rq.exp = '0;
        send_request(rq);

        // Largest 64-bit prime with a random private key.
        pbig = 64'hffff_ffff_ffff_ffc5;
        d = rand64();
        load_key(pbig, 64'd5, powmod(64'd5, d, pbig), d);
        for (int i = 0; i < 12; i++) begin
            sign_and_verify(64'hffff_ffff);
        end
        send_request(make_request(OP_VERIFY, rand64(), 64'd0, rand64(), rand64()));

        send_idle_pct = 61;
        recv_idle_pct = 34;
        // Sender holds off until the block has drained.
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        d = rand64() % 64'd1018;
        load_key(64'd1019, 64'd2, powmod(64'd2, d, 64'd1019), d);
        for (int i = 0; i < 15; i++) begin
            sign_and_verify(64'd2000);
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_key(rand64() | 64'd3, rand64(), rand64(), '1);
        for (int i = 0; i < 10; i++) begin
            if ($urandom_range(1) == 0) begin
                send_request(make_request(OP_SIGN, rand64(), rand64(), rand64(), rand64()));
            end else begin
                send_request(make_request(OP_VERIFY, rand64(), rand64(),
                    ($urandom_range(1) == 0) ? rand64() : rand64() % key_p, rand64()));
            end
        end
        d = rand64();
        load_key(64'd23, 64'd5, powmod(64'd5, d, 64'd23), d);
        for (int i = 0; i < 12; i++) begin
            sign_and_verify(64'd1000);
        end

        wait_drained();
        $display("Covered %0d signs (%0d with nonce errors) and %0d verifies (%0d accepted).",
            sign_count, nonce_err_count, verify_count, accept_count);
        $display("Keys included the reset key, a modulus below three and the largest prime.");
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/eg_pkg.sv
rtl/core/eg_mul.sv
rtl/core/eg_pow.sv
rtl/core/elgamal_sign_verify.sv
rtl/core/eg_checker.sv
dv/elgamal_sign_verify_tb.sv
